[rtl/ssq_pkg.sv]
// Shared types, constants and the half-step table for the sweep sequencer.
`default_nettype none

package ssq_pkg;

  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned DEG_W     = 9;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned STEP_W    = 13;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned COIL_W    = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 16;

  localparam int unsigned MAX_DEG   = 360;
  localparam int unsigned MAX_STEPS = 8191;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(1000);
  localparam logic [DEG_W-1:0]    DEG_RST    = DEG_W'(MAX_DEG);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RUN   = 2'd1,
    OP_STOP  = 2'd2,
    OP_COUNT = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_PERIOD   = 1'b0,
    REG_SWEEP_DEGREES = 1'b1
  } reg_e;

  typedef struct packed {
    logic [PHASE_W-1:0]  phase_index;
    logic [COIL_W-1:0]   coil_pattern;
    logic [STEP_W-1:0]   steps_left;
    logic [STEP_W-1:0]   sweep_steps;
    logic                reverse_phase;
    logic [CNT_W-1:0]    cycles_left;
    logic [PERIOD_W-1:0] tick_countdown;
    logic                run_forever;
    logic                running;
  } ssq_state_t;

  function automatic logic [COIL_W-1:0] half_step(input logic [PHASE_W-1:0] idx);
    logic [COIL_W-1:0] pat;
    case (idx)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      3'd7:    pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

[rtl/ssq_if.sv]
// Valid/ready channel interfaces: command items, result items and register writes.
`default_nettype none

interface ssq_in_if import ssq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       op;
  logic [CNT_W-1:0] sweep_count;

  modport source (output valid, output op, output sweep_count, input ready);
  modport sink (input valid, input op, input sweep_count, output ready);
endinterface

interface ssq_out_if import ssq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COIL_W-1:0] coils;
  logic              pump_on;
  logic              busy_res;

  modport source (output valid, output coils, output pump_on, output busy_res, input ready);
  modport sink (input valid, input coils, input pump_on, input busy_res, output ready);
endinterface

interface ssq_cfg_if import ssq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/ssq_core.sv]
// Next-state logic of the sweep sequencer for one command item.
`default_nettype none

module ssq_core import ssq_pkg::*; (
  input  ssq_state_t          state_i,
  input  op_e                 op_i,
  input  logic [CNT_W-1:0]    sweep_count_i,
  input  logic [PERIOD_W-1:0] step_period_i,
  input  logic [STEP_W-1:0]   sweep_len_i,
  output ssq_state_t          state_o
);

  ssq_state_t        nxt;
  logic              done;
  logic [PHASE_W-1:0] idx;

  always_comb begin
    nxt  = state_i;
    done = 1'b0;
    idx  = '0;
    case (op_i)
      OP_TICK: begin
        if (state_i.running) begin
          if (state_i.tick_countdown != '0) begin
            nxt.tick_countdown = state_i.tick_countdown - PERIOD_W'(1);
          end else begin
            // zero period behaves as one
            nxt.tick_countdown = (step_period_i == '0) ? '0 :
                                 step_period_i - PERIOD_W'(1);
            // roll over finished sweeps; a zero-length sweep can roll twice
            for (int pass = 0; pass < 2; pass++) begin
              if (!done && nxt.steps_left == '0) begin
                if (nxt.reverse_phase) begin
                  nxt.reverse_phase = 1'b0;
                end else if (!nxt.run_forever && nxt.cycles_left == CNT_W'(1)) begin
                  nxt.running        = 1'b0;
                  nxt.run_forever    = 1'b0;
                  nxt.cycles_left    = '0;
                  nxt.tick_countdown = '0;
                  done               = 1'b1;
                end else begin
                  if (!nxt.run_forever) begin
                    nxt.cycles_left = nxt.cycles_left - CNT_W'(1);
                  end
                  nxt.reverse_phase = 1'b1;
                end
                if (!done) begin
                  nxt.steps_left  = nxt.sweep_steps;
                  nxt.phase_index = '0;
                end
              end
            end
            if (!done && nxt.steps_left != '0) begin
              nxt.phase_index = nxt.phase_index + PHASE_W'(1);
              idx = nxt.reverse_phase ? PHASE_W'(0) - nxt.phase_index : nxt.phase_index;
              nxt.coil_pattern = half_step(idx);
              nxt.steps_left   = nxt.steps_left - STEP_W'(1);
            end
          end
        end
      end
      OP_RUN: begin
        if (!state_i.running) begin
          nxt.sweep_steps    = sweep_len_i;
          nxt.steps_left     = sweep_len_i;
          nxt.reverse_phase  = 1'b1;
          nxt.phase_index    = '0;
          nxt.run_forever    = 1'b1;
          nxt.cycles_left    = '0;
          nxt.tick_countdown = '0;
          nxt.running        = 1'b1;
        end
      end
      OP_STOP: begin
        // coils hold their last pattern
        if (state_i.running) begin
          nxt.running        = 1'b0;
          nxt.run_forever    = 1'b0;
          nxt.cycles_left    = '0;
          nxt.steps_left     = '0;
          nxt.tick_countdown = '0;
        end
      end
      OP_COUNT: begin
        if (!state_i.running && sweep_count_i != '0) begin
          nxt.sweep_steps    = sweep_len_i;
          nxt.steps_left     = sweep_len_i;
          nxt.reverse_phase  = 1'b1;
          nxt.phase_index    = '0;
          nxt.run_forever    = 1'b0;
          nxt.cycles_left    = sweep_count_i;
          nxt.tick_countdown = '0;
          nxt.running        = 1'b1;
        end
      end
      default: begin
        nxt = state_i;
      end
    endcase
  end

  assign state_o = nxt;

endmodule

`default_nettype wire

[rtl/sprinkler_sweep_sequencer.sv]
// Top level of the sprinkler sweep sequencer: command register, state, result register.
// Path: an accepted item passes the command register, then the result register.
//   The state update is one short combinational pass.
// Throughput: one item per cycle unless a held result is not taken.
// Sweep length is registered from sweep_degrees in the cycle after a register write.
// Reset: asynchronous, active low; sequencer idle, step_period 1000, sweep_degrees 360,
//   no item held; the coils output register is not reset.
`default_nettype none

module sprinkler_sweep_sequencer import ssq_pkg::*; #(
  parameter int unsigned STEPS_PER_TURN = 4096
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ssq_in_if.sink      in_i,
  ssq_out_if.source   out_o,
  ssq_cfg_if.sink     cfg_i
);

  // floor(STEPS_PER_TURN * deg / 360) as deg * M >> FRAC_W, exact for deg <= 360
  localparam int unsigned FRAC_W     = 20;
  localparam logic [63:0] SWEEP_MULT =
      ((64'(STEPS_PER_TURN) << FRAC_W) + 64'(MAX_DEG - 1)) / 64'(MAX_DEG);
  localparam int unsigned MULT_W     = $clog2(SWEEP_MULT + 64'd1);
  localparam int unsigned PROD_W     = DEG_W + MULT_W;
  localparam logic [STEP_W-1:0] SWEEP_LEN_RST =
      (STEPS_PER_TURN > MAX_STEPS) ? STEP_W'(MAX_STEPS) : STEP_W'(STEPS_PER_TURN);

  logic [PERIOD_W-1:0] step_period_q;
  logic [DEG_W-1:0]    sweep_degrees_q;
  logic [DEG_W-1:0]    deg_eff;
  logic [PROD_W-1:0]   sweep_prod;
  logic [PROD_W-1:0]   sweep_full;
  logic [STEP_W-1:0]   sweep_len_d, sweep_len_q;

  logic                in_valid_q;
  logic [1:0]          op_q;
  logic [CNT_W-1:0]    sweep_count_q;
  logic                advance;

  ssq_state_t          state_d, state_q;

  logic                out_valid_q;
  logic [COIL_W-1:0]   coils_q;
  logic                running_q;

  // register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_period_q   <= PERIOD_RST;
      sweep_degrees_q <= DEG_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (reg_e'(cfg_i.index))
        REG_STEP_PERIOD:   step_period_q   <= cfg_i.data[PERIOD_W-1:0];
        REG_SWEEP_DEGREES: sweep_degrees_q <= cfg_i.data[DEG_W-1:0];
        default: begin
          step_period_q <= step_period_q;
        end
      endcase
    end
  end

  // sweep length from the angle, clamped to a full turn and to the counter range
  assign deg_eff    = (sweep_degrees_q > DEG_W'(MAX_DEG)) ? DEG_W'(MAX_DEG) : sweep_degrees_q;
  assign sweep_prod = PROD_W'(deg_eff) * PROD_W'(SWEEP_MULT[MULT_W-1:0]);
  assign sweep_full = sweep_prod >> FRAC_W;
  assign sweep_len_d = (sweep_full > PROD_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) :
                       sweep_full[STEP_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_len_q <= SWEEP_LEN_RST;
    end else begin
      sweep_len_q <= sweep_len_d;
    end
  end

  // command register: refill whenever the held item moves on
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q          <= in_i.op;
      sweep_count_q <= in_i.sweep_count;
    end
  end

  ssq_core u_core (
    .state_i       (state_q),
    .op_i          (op_e'(op_q)),
    .sweep_count_i (sweep_count_q),
    .step_period_i (step_period_q),
    .sweep_len_i   (sweep_len_q),
    .state_o       (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      coils_q   <= state_d.coil_pattern;
      running_q <= state_d.running;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.coils    = coils_q;
  assign out_o.pump_on  = running_q;
  assign out_o.busy_res = running_q;

  // idle leaves no sweep, count or tick residue behind
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.running |-> (state_q.steps_left == '0 && state_q.cycles_left == '0 &&
                          state_q.tick_countdown == '0 && !state_q.run_forever))
    else $error("idle sequencer holds stale run state");

  // a counted run always has a cycle left
  a_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.running && !state_q.run_forever) |-> state_q.cycles_left != '0)
    else $error("counted run active with no cycles left");

  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.steps_left <= state_q.sweep_steps)
    else $error("steps_left exceeds sweep length");

  // a stalled command stays held until the result slot frees
  a_hold_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(op_q) && $stable(sweep_count_q)))
    else $error("held command item lost while stalled");

endmodule

`default_nettype wire
